### hw/rtl/u8v_pkg.sv
package u8v_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_STRAY_CONT = 3'd1,
    ST_BAD_LEAD   = 3'd2,
    ST_MISSING    = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  localparam int unsigned CP_W = 31;

  typedef struct packed {
    logic [2:0]      pending;
    logic [CP_W-1:0] acc;
    logic            err;
    logic            finished;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            has_char;
    status_t         status;
    logic            eos;
    logic            string_valid;
  } dec_result_t;

endpackage

### hw/rtl/u8v_decode.sv
module u8v_decode
  import u8v_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  input  logic        nul_ends_string,
  output dec_state_t  nxt,
  output dec_result_t res,
  output logic        produce
);

  logic    nul_end;
  logic    eos;
  logic    has;
  status_t st;
  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] acc_shift;
  logic    is_nul;

  assign acc_shift = {cur.acc[CP_W-7:0], byte_in[5:0]};
  assign is_nul    = (byte_in == 8'h00) && nul_ends_string;

  always_comb begin
    nxt     = cur;
    nul_end = 1'b0;
    eos     = 1'b0;
    has     = 1'b0;
    st      = ST_OK;
    cp      = '0;
    produce = 1'b0;
    res     = '0;

    if (cur.finished) begin
      if (last_byte) begin
        nxt.finished = 1'b0;
      end
    end else begin
      if (cur.err) begin
        eos = last_byte;
      end else if (cur.pending != 3'd0) begin
        if (byte_in[7:6] == 2'b10) begin
          nxt.acc     = acc_shift;
          nxt.pending = cur.pending - 3'd1;
          if (cur.pending == 3'd1) begin
            has = 1'b1;
            cp  = acc_shift;
          end
        end else begin
          st      = ST_MISSING;
          nul_end = is_nul;
        end
      end else if (is_nul) begin
        nul_end = 1'b1;
      end else if (!byte_in[7]) begin
        has = 1'b1;
        cp  = {{(CP_W-8){1'b0}}, byte_in};
      end else if (!byte_in[6]) begin
        st = ST_STRAY_CONT;
      end else if (!byte_in[5]) begin
        nxt.pending = 3'd1;
        nxt.acc     = {{(CP_W-5){1'b0}}, byte_in[4:0]};
      end else if (!byte_in[4]) begin
        nxt.pending = 3'd2;
        nxt.acc     = {{(CP_W-4){1'b0}}, byte_in[3:0]};
      end else if (!byte_in[3]) begin
        nxt.pending = 3'd3;
        nxt.acc     = {{(CP_W-3){1'b0}}, byte_in[2:0]};
      end else if (!byte_in[2]) begin
        nxt.pending = 3'd4;
        nxt.acc     = {{(CP_W-2){1'b0}}, byte_in[1:0]};
      end else if (!byte_in[1]) begin
        nxt.pending = 3'd5;
        nxt.acc     = {{(CP_W-1){1'b0}}, byte_in[0]};
      end else begin
        st = ST_BAD_LEAD;
      end

      if (st != ST_OK) begin
        nxt.err     = 1'b1;
        nxt.pending = 3'd0;
        nxt.acc     = '0;
      end

      if (last_byte || nul_end) begin
        eos = 1'b1;
        if (st == ST_OK && !nxt.err && nxt.pending != 3'd0) begin
          st      = ST_TRUNCATED;
          nxt.err = 1'b1;
        end
      end

      produce          = has || (st != ST_OK) || eos;
      res.code_point   = cp;
      res.has_char     = has;
      res.status       = st;
      res.eos          = eos;
      res.string_valid = eos && !nxt.err;

      if (eos) begin
        nxt.pending = 3'd0;
        nxt.acc     = '0;
        nxt.err     = 1'b0;
        if (nul_end && !last_byte) begin
          nxt.finished = 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/u8v_out_reg.sv
module u8v_out_reg
  import u8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  dec_result_t res_in,
  input  logic        stall,
  output logic        can_load,
  output logic        valid,
  output dec_result_t res
);

  assign can_load = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res <= res_in;
    end
  end

endmodule

### hw/rtl/utf8_validating_decoder_core.sv
// UTF-8 validating decoder (six-byte form). One byte is accepted per clock
// while in_stall is low. An accepted byte is held in the input register until
// it advances. If it causes a result, that result is decoded from the input
// register and loaded into the result register, which drives the outputs.
// The rate is one byte per cycle while the result side does not stall, set by
// the decode state register, which is updated once per byte by a single pass
// of decode logic. Stall on the result side propagates back to the input
// stall in the same cycle. Errors are sticky until end of string.
module utf8_validating_decoder_core
  import u8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] code_point,
  output logic        has_char,
  output logic [2:0]  status,
  output logic        end_of_string,
  output logic        string_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic        nul_ends_string;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t dec_res;
  dec_result_t out_res;
  logic        produce;
  logic        can_load;
  logic        s1_advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nul_ends_string <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      nul_ends_string <= cfg_data;
    end
  end

  assign s1_advance = s1_valid && (!produce || can_load);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= byte_in;
      s1_last <= last_byte;
    end
  end

  u8v_decode u_decode (
    .cur             (state),
    .byte_in         (s1_byte),
    .last_byte       (s1_last),
    .nul_ends_string (nul_ends_string),
    .nxt             (state_next),
    .res             (dec_res),
    .produce         (produce)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  u8v_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_valid && produce),
    .res_in   (dec_res),
    .stall    (out_stall),
    .can_load (can_load),
    .valid    (out_valid),
    .res      (out_res)
  );

  assign code_point    = out_res.code_point;
  assign has_char      = out_res.has_char;
  assign status        = out_res.status;
  assign end_of_string = out_res.eos;
  assign string_valid  = out_res.string_valid;

`ifndef SYNTH
  a_valid_at_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!string_valid || end_of_string))
    else $error("string_valid without end of string");

  a_char_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |-> (status == ST_OK))
    else $error("code point carried with error status");

  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    state.finished |-> (state.pending == 3'd0 && !state.err))
    else $error("open sequence after string end");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
